// ===== src/crc_checked_frame_receiver_core_assert.svh =====
// Assertion macros shared by the frame receiver modules.
// Needs nothing else; each macro checks on the rising clock edge outside reset.
`ifndef CRC_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver assertion failed");

// Next-cycle implication.
`define CFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver assertion failed");

`endif

// ===== src/cfr_pkg.sv =====
// Package for the checked frame receiver: codes, reset values and the CRC step.
// Used by cfr_parser, the top level and the testbench.
`timescale 1ns / 1ps
package cfr_pkg;

  localparam logic       OP_FEED = 1'b0;
  localparam logic       OP_READ = 1'b1;

  localparam logic       KIND_FRAME = 1'b0;
  localparam logic       KIND_READ  = 1'b1;

  localparam int         CFG_IDX_W = 2;
  localparam int         CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [7:0] START_FIRST_RST  = 8'hA5;
  localparam logic [7:0] START_SECOND_RST = 8'h5A;
  localparam logic [8:0] PAYLOAD_LIMIT_RST = 9'd256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Header positions of the little-endian payload length.
  localparam int         LEN_LO_POS = 8;
  localparam int         LEN_HI_POS = 9;

  typedef struct packed {
    logic       good;
    logic [8:0] len;
  } cfr_frame_t;

  // One byte of CRC-16/Modbus, reflected, bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/cfr_if.sv =====
// Handshake channels of the frame receiver: input items and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic [8:0] read_index;

  modport source (output valid, op, data_byte, read_index, input ready);
  modport sink (input valid, op, data_byte, read_index, output ready);
endinterface

interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [8:0] frame_length;
  logic [7:0] read_data;

  modport source (output valid, kind, frame_length, read_data, input ready);
  modport sink (input valid, kind, frame_length, read_data, output ready);
endinterface

// ===== src/cfr_store.sv =====
// Frame store: one write port and one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module cfr_store #(
  parameter int Depth = 268,
  parameter int AddrW = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read so that a stalled beat keeps its byte.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cfr_parser.sv =====
// Frame parser: start-byte hunt, header and payload tracking, running CRC.
// Uses cfr_pkg; drives the write port of cfr_store.
`timescale 1ns / 1ps
`include "crc_checked_frame_receiver_core_assert.svh"
module cfr_parser import cfr_pkg::*; #(
  parameter int HeaderBytes = 10,
  parameter int MaxPayload  = 256,
  parameter int AddrW       = 9,
  parameter int PosW        = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       start_first_i,
  input  logic [7:0]       start_second_i,
  input  logic [8:0]       payload_limit_i,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [7:0]       wr_data_o,
  output cfr_frame_t       frame_o
);

  localparam int SumW = 17;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SECOND  = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic [7:0]      crc_lo_q, crc_lo_d;

  logic [PosW-1:0] pos_inc;
  logic [15:0]     hdr_len;
  logic [15:0]     limit;
  logic [15:0]     crc_next;
  logic [SumW-1:0] payload_end;

  assign pos_inc     = pos_q + PosW'(1);
  assign crc_next    = crc_byte(crc_q, byte_i);
  assign payload_end = SumW'(HeaderBytes) + SumW'(len_q);
  assign limit       = (16'(payload_limit_i) < 16'(MaxPayload)) ?
                       16'(payload_limit_i) : 16'(MaxPayload);
  // The last header byte may itself carry a length byte.
  assign hdr_len = {(32'(pos_q) == LEN_HI_POS) ? byte_i : len_hi_q,
                    (32'(pos_q) == LEN_LO_POS) ? byte_i : len_lo_q};

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_d     = len_q;
    crc_d     = crc_q;
    len_lo_d  = len_lo_q;
    len_hi_d  = len_hi_q;
    crc_lo_d  = crc_lo_q;
    wr_en_o   = 1'b0;
    wr_addr_o = AddrW'(pos_q);
    wr_data_o = byte_i;
    frame_o   = '0;
    if (en_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == start_first_i) begin
            wr_en_o   = 1'b1;
            wr_addr_o = '0;
            pos_d     = PosW'(1);
            crc_d     = crc_byte(CRC_INIT, byte_i);
            phase_d   = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (byte_i == start_second_i) begin
            wr_en_o = 1'b1;
            pos_d   = pos_inc;
            crc_d   = crc_next;
            phase_d = PH_HEADER;
          end else if (byte_i == start_first_i) begin
            wr_en_o   = 1'b1;
            wr_addr_o = '0;
            pos_d     = PosW'(1);
            crc_d     = crc_byte(CRC_INIT, byte_i);
          end else begin
            phase_d = PH_HUNT;
            pos_d   = '0;
          end
        end
        PH_HEADER: begin
          wr_en_o = 1'b1;
          pos_d   = pos_inc;
          crc_d   = crc_next;
          if (32'(pos_q) == LEN_LO_POS) begin
            len_lo_d = byte_i;
          end
          if (32'(pos_q) == LEN_HI_POS) begin
            len_hi_d = byte_i;
          end
          if (32'(pos_inc) >= HeaderBytes) begin
            len_d = hdr_len;
            if (hdr_len > limit) begin
              phase_d = PH_HUNT;
              pos_d   = '0;
            end else if (hdr_len == 16'd0) begin
              phase_d = PH_CRC;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          wr_en_o = 1'b1;
          pos_d   = pos_inc;
          crc_d   = crc_next;
          if (SumW'(pos_inc) >= payload_end) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          wr_en_o  = 1'b1;
          pos_d    = pos_inc;
          crc_lo_d = byte_i;
          // The second CRC byte closes the frame; the first was kept in crc_lo_q.
          if (SumW'(pos_inc) >= payload_end + SumW'(2)) begin
            frame_o.good = ({byte_i, crc_lo_q} == crc_q);
            frame_o.len  = 9'(pos_inc);
            phase_d      = PH_HUNT;
            pos_d        = '0;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          pos_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      pos_q    <= '0;
      len_q    <= '0;
      crc_q    <= CRC_INIT;
      len_lo_q <= '0;
      len_hi_q <= '0;
      crc_lo_q <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      len_lo_q <= len_lo_d;
      len_hi_q <= len_hi_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  `CFR_ASSERT_NOW(a_payload_nonzero, clk_i, rst_ni, phase_q == PH_PAYLOAD, len_q != 16'd0)
  `CFR_ASSERT_NOW(a_crc_after_header, clk_i, rst_ni, phase_q == PH_CRC, 32'(pos_q) >= HeaderBytes)
  `CFR_ASSERT_NOW(a_good_needs_enable, clk_i, rst_ni, frame_o.good, en_i && phase_q == PH_CRC)

endmodule

// ===== src/crc_checked_frame_receiver_core.sv =====
// Checked frame receiver, top level: configuration, parser, frame store, result stages.
// Uses cfr_pkg, cfr_if, cfr_parser and cfr_store.
// Path: an accepted item is registered in stage one (with the store read), then in the output register.
// Throughput: one item per cycle while the result side is not stalled; a fed byte and a read each use one memory port.
// Reset restores parse state, CRC, configuration and result valids; frame store is not cleared.
`timescale 1ns / 1ps
`include "crc_checked_frame_receiver_core_assert.svh"
module crc_checked_frame_receiver_core import cfr_pkg::*; #(
  parameter int MAX_PAYLOAD  = 256,
  parameter int HEADER_BYTES = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cfr_in_if.sink                in_i,
  cfr_out_if.source             out_o
);

  localparam int Depth = HEADER_BYTES + MAX_PAYLOAD + 2;
  localparam int AddrW = $clog2(Depth);
  localparam int PosW  = $clog2(Depth + 1);

  logic [7:0] start_first_q;
  logic [7:0] start_second_q;
  logic [8:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_first_q  <= START_FIRST_RST;
      start_second_q <= START_SECOND_RST;
      limit_q        <= PAYLOAD_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_FIRST:   start_first_q  <= cfg_data_i[7:0];
        REG_START_SECOND:  start_second_q <= cfg_data_i[7:0];
        REG_PAYLOAD_LIMIT: limit_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             accept;
  logic             feed;
  logic             rd;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [7:0]       rdata;
  cfr_frame_t       frame;

  assign accept = in_i.valid && in_i.ready;
  assign feed   = accept && (in_i.op == OP_FEED);
  assign rd     = accept && (in_i.op == OP_READ);

  cfr_parser #(
    .HeaderBytes(HEADER_BYTES),
    .MaxPayload (MAX_PAYLOAD),
    .AddrW      (AddrW),
    .PosW       (PosW)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (feed),
    .byte_i         (in_i.data_byte),
    .start_first_i  (start_first_q),
    .start_second_i (start_second_q),
    .payload_limit_i(limit_q),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .frame_o        (frame)
  );

  cfr_store #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd),
    .raddr_i(AddrW'(in_i.read_index)),
    .rdata_o(rdata)
  );

  // Stage one waits on the store read; the output register then parts the
  // result side from the input side.
  logic       s1_valid_q, s1_valid_d;
  logic       s1_kind_q;
  logic [8:0] s1_len_q;
  logic       s1_inrange_q;
  logic       s1_load;
  logic       s1_adv;

  logic       out_valid_q, out_valid_d;
  logic       out_kind_q;
  logic [8:0] out_len_q;
  logic [7:0] out_data_q;

  assign s1_load = rd || frame.good;
  assign s1_adv  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_kind_q    <= rd ? KIND_READ : KIND_FRAME;
      s1_len_q     <= rd ? 9'd0 : frame.len;
      s1_inrange_q <= 32'(in_i.read_index) < Depth;
    end
    if (s1_adv) begin
      out_kind_q <= s1_kind_q;
      out_len_q  <= s1_len_q;
      out_data_q <= (s1_kind_q == KIND_READ && s1_inrange_q) ? rdata : 8'd0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.frame_length = out_len_q;
  assign out_o.read_data    = out_data_q;

  `CFR_ASSERT_NOW(a_stall_blocks_input, clk_i, rst_ni, s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready)
  `CFR_ASSERT_NEXT(a_read_reaches_s1, clk_i, rst_ni, rd, s1_valid_q && s1_kind_q == KIND_READ)
  `CFR_ASSERT_NOW(a_no_write_on_read, clk_i, rst_ni, rd, !wr_en && !frame.good)

endmodule

// ===== dv/crc_checked_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for crc_checked_frame_receiver_core: feeds link bytes and store reads through
// the handshake channels, predicts every result beat with a shadow parser and checks them.
// Depends on cfr_pkg, the cfr_in_if and cfr_out_if interfaces and the receiver RTL.
module crc_checked_frame_receiver_core_tb import cfr_pkg::*;;

  localparam int HEADER_LEN    = 10;
  localparam int PAYLOAD_MAX   = 256;
  localparam int STORE_SIZE    = HEADER_LEN + PAYLOAD_MAX + 2;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int WHOLE_FRAME   = 1 << 30;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_HEADER, TAKE_PAYLOAD, TAKE_CRC
  } rx_phase_e;

  typedef struct packed {
    logic       kind;
    logic [8:0] frame_length;
    logic [7:0] read_data;
  } result_beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cfr_in_if  feed_bus ();
  cfr_out_if result_bus ();

  crc_checked_frame_receiver_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (feed_bus),
    .out_o      (result_bus)
  );

  // Shadow copies of the registers and of the parser.
  logic [7:0]  sof_first  = START_FIRST_RST;
  logic [7:0]  sof_second = START_SECOND_RST;
  logic [8:0]  len_limit  = PAYLOAD_LIMIT_RST;
  rx_phase_e   rx_phase   = HUNT_FIRST;
  int unsigned rx_pos     = 0;
  int unsigned rx_len     = 0;
  logic [15:0] rx_crc     = CRC_INIT;
  logic [7:0]  shadow_store [STORE_SIZE];
  bit          shadow_written [STORE_SIZE];

  result_beat_t awaited_beats [$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int unsigned items_sent     = 0;
  bit          idle_enable    = 1'b1;
  bit          hold_request   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] modbus_step(logic [15:0] crc, logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ d[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic int unsigned usable_limit();
    return (len_limit < PAYLOAD_MAX) ? len_limit : PAYLOAD_MAX;
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    if (rx_pos < STORE_SIZE) begin
      shadow_store[rx_pos]   = b;
      shadow_written[rx_pos] = 1'b1;
    end
    rx_pos++;
  endfunction

  function automatic void open_frame(logic [7:0] b);
    rx_pos = 0;
    keep_byte(b);
    rx_crc = modbus_step(CRC_INIT, b);
  endfunction

  function automatic void abandon_frame();
    rx_phase = HUNT_FIRST;
    rx_pos   = 0;
  endfunction

  // Advances the shadow parser by one link byte; returns 1 when a good frame completes.
  function automatic bit parse_link_byte(logic [7:0] b, output logic [8:0] total);
    logic [15:0] crc_rx;
    total = '0;
    case (rx_phase)
      HUNT_FIRST: begin
        if (b == sof_first) begin
          open_frame(b);
          rx_phase = HUNT_SECOND;
        end
      end
      HUNT_SECOND: begin
        // The second start byte wins when both start bytes are equal.
        if (b == sof_second) begin
          keep_byte(b);
          rx_crc   = modbus_step(rx_crc, b);
          rx_phase = TAKE_HEADER;
        end else if (b == sof_first) begin
          open_frame(b);
        end else begin
          abandon_frame();
        end
      end
      TAKE_HEADER: begin
        keep_byte(b);
        rx_crc = modbus_step(rx_crc, b);
        if (rx_pos >= HEADER_LEN) begin
          rx_len = {shadow_store[LEN_HI_POS], shadow_store[LEN_LO_POS]};
          if (rx_len > usable_limit()) begin
            abandon_frame();
          end else if (rx_len == 0) begin
            rx_phase = TAKE_CRC;
          end else begin
            rx_phase = TAKE_PAYLOAD;
          end
        end
      end
      TAKE_PAYLOAD: begin
        keep_byte(b);
        rx_crc = modbus_step(rx_crc, b);
        if (rx_pos >= HEADER_LEN + rx_len) begin
          rx_phase = TAKE_CRC;
        end
      end
      TAKE_CRC: begin
        keep_byte(b);
        if (rx_pos >= HEADER_LEN + rx_len + 2) begin
          crc_rx = {shadow_store[rx_pos - 1], shadow_store[rx_pos - 2]};
          total  = 9'(rx_pos);
          abandon_frame();
          return crc_rx == rx_crc;
        end
      end
      default: begin
        abandon_frame();
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [8:0] pick_read_index();
    logic [8:0] idx;
    if (!shadow_written[0] || $urandom_range(0, 7) == 0) begin
      return 9'($urandom_range(STORE_SIZE, 511));
    end
    do begin
      idx = 9'($urandom_range(0, STORE_SIZE - 1));
    end while (!shadow_written[idx]);
    return idx;
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Offers one beat, waits for the handshake and records what it should produce.
  task automatic send_item(logic op, logic [7:0] b, logic [8:0] idx);
    logic [8:0]   total;
    result_beat_t beat;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      feed_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    feed_bus.valid      <= 1'b1;
    feed_bus.op         <= op;
    feed_bus.data_byte  <= b;
    feed_bus.read_index <= idx;
    do @(posedge clk_i); while (feed_bus.ready !== 1'b1);
    items_sent++;
    beat = '0;
    if (op == OP_READ) begin
      beat.kind      = KIND_READ;
      beat.read_data = (idx < STORE_SIZE) ? shadow_store[idx] : 8'h00;
      awaited_beats.push_back(beat);
    end else if (parse_link_byte(b, total)) begin
      beat.kind         = KIND_FRAME;
      beat.frame_length = total;
      awaited_beats.push_back(beat);
    end
  endtask

  task automatic feed_byte(logic [7:0] b);
    send_item(OP_FEED, b, 9'($urandom_range(0, 511)));
  endtask

  task automatic read_byte(logic [8:0] idx);
    send_item(OP_READ, 8'($urandom), idx);
  endtask

  // Builds a frame for the current start bytes and feeds it up to cut_at, with random reads
  // mixed in. Oversized lengths stop after the header, since the block drops the frame there.
  task automatic send_frame(int unsigned plen, bit bad_crc, int cut_at, int read_odds);
    logic [7:0]  fr [$];
    logic [15:0] crc;
    fr.push_back(sof_first);
    fr.push_back(sof_second);
    repeat (HEADER_LEN - 4) fr.push_back(8'($urandom));
    fr.push_back(plen[7:0]);
    fr.push_back(plen[15:8]);
    if (plen <= usable_limit()) begin
      repeat (plen) fr.push_back(8'($urandom));
      crc = CRC_INIT;
      foreach (fr[i]) crc = modbus_step(crc, fr[i]);
      if (bad_crc) begin
        crc = crc ^ (16'd1 << $urandom_range(0, 15));
      end
      fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
    end
    foreach (fr[i]) begin
      if (i >= cut_at) break;
      if (read_odds > 0 && $urandom_range(1, read_odds) == 1) begin
        read_byte(pick_read_index());
      end
      feed_byte(fr[i]);
    end
  endtask

  // Feeds filler until the parser is hunting again, so that the next frame is seen whole.
  task automatic resync();
    logic [7:0] b;
    while (rx_phase != HUNT_FIRST) begin
      do begin
        b = 8'($urandom);
      end while (rx_phase == HUNT_SECOND && (b == sof_first || b == sof_second));
      feed_byte(b);
    end
  endtask

  task automatic wait_drained();
    feed_bus.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_START_FIRST:   sof_first  = val[7:0];
      REG_START_SECOND:  sof_second = val[7:0];
      REG_PAYLOAD_LIMIT: len_limit  = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [7:0] first, logic [7:0] second, logic [8:0] limit);
    wait_drained();
    write_reg(REG_START_FIRST, {1'b0, first});
    write_reg(REG_START_SECOND, {1'b0, second});
    write_reg(REG_PAYLOAD_LIMIT, limit);
  endtask

  task automatic test_good_frames();
    send_frame(0, 1'b0, WHOLE_FRAME, 0);
    send_frame(3, 1'b0, WHOLE_FRAME, 0);
    read_byte(9'd0);
    read_byte(9'd9);
    read_byte(9'(STORE_SIZE));
    read_byte(9'h1FF);
  endtask

  task automatic test_start_hunt();
    feed_byte(8'h13);
    feed_byte(sof_first);
    feed_byte(8'h00);
    // A repeated first start byte restarts the wait for the second.
    feed_byte(sof_first);
    feed_byte(sof_first);
    send_frame(1, 1'b0, WHOLE_FRAME, 0);
  endtask

  task automatic test_dropped_frames();
    send_frame(0, 1'b1, WHOLE_FRAME, 0);
    send_frame(16'h0101, 1'b0, WHOLE_FRAME, 0);
  endtask

  task automatic test_longest_frame();
    send_frame(PAYLOAD_MAX, 1'b0, WHOLE_FRAME, 0);
    read_byte(9'(STORE_SIZE - 2));
    read_byte(9'(STORE_SIZE - 1));
  endtask

  task automatic test_equal_start_bytes();
    apply_settings(8'h00, 8'h00, 9'd0);
    send_frame(0, 1'b0, WHOLE_FRAME, 0);
    send_frame(1, 1'b0, WHOLE_FRAME, 0);
  endtask

  task automatic test_register_map();
    apply_settings(8'hFF, 8'h00, 9'd256);
    // Index 3 is unmapped; the write must leave every register alone.
    write_reg(REG_UNMAPPED, 9'h1FF);
    send_frame(2, 1'b0, WHOLE_FRAME, 0);
  endtask

  task automatic test_backpressure();
    idle_enable  = 1'b0;
    hold_request = 1'b1;
    repeat (12) read_byte(pick_read_index());
    send_frame(4, 1'b0, WHOLE_FRAME, 0);
    wait_drained();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned stop_at;
    int unsigned lim;
    int unsigned plen;
    stop_at = items_sent + n_items;
    lim     = usable_limit();
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          resync();
          if ($urandom_range(0, 11) == 0) begin
            plen = $urandom_range(lim + 1, 65535);
          end else if ($urandom_range(0, 9) == 0) begin
            plen = $urandom_range(0, lim);
          end else begin
            plen = $urandom_range(0, (lim < 12) ? lim : 12);
          end
          send_frame(plen, $urandom_range(0, 7) == 0, WHOLE_FRAME, 10);
        end
        6: begin
          resync();
          send_frame($urandom_range(0, lim), 1'b0, $urandom_range(1, HEADER_LEN + 4), 10);
        end
        7: begin
          repeat ($urandom_range(1, 4)) feed_byte(8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 3)) read_byte(pick_read_index());
        end
      endcase
    end
  endtask

  // Result side: random stall bursts, and one long hold-off on request.
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_beat_t want;
    if (rst_ni && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (awaited_beats.size() == 0) begin
        flag_mismatch("unexpected result beat, kind", 16'(result_bus.kind), 16'hFFFF);
      end else begin
        want = awaited_beats.pop_front();
        if (result_bus.kind !== want.kind) begin
          flag_mismatch("kind", 16'(result_bus.kind), 16'(want.kind));
        end
        if (result_bus.frame_length !== want.frame_length) begin
          flag_mismatch("frame_length", 16'(result_bus.frame_length), 16'(want.frame_length));
        end
        if (result_bus.read_data !== want.read_data) begin
          flag_mismatch("read_data", 16'(result_bus.read_data), 16'(want.read_data));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((feed_bus.valid === 1'b1 && feed_bus.ready === 1'b1) ||
        (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, awaited_beats.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    feed_bus.valid      <= 1'b0;
    feed_bus.op         <= OP_FEED;
    feed_bus.data_byte  <= '0;
    feed_bus.read_index <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_good_frames();
    test_start_hunt();
    test_dropped_frames();
    test_longest_frame();
    test_equal_start_bytes();
    test_register_map();
    test_backpressure();

    apply_settings(START_FIRST_RST, START_SECOND_RST, PAYLOAD_LIMIT_RST);
    test_random_traffic(10);
    apply_settings(8'h00, 8'hFF, 9'd0);
    test_random_traffic(10);
    apply_settings(8'hFF, 8'hFF, 9'd17);
    test_random_traffic(10);
    // The closing stretch runs with no idling on either side.
    idle_enable = 1'b0;
    apply_settings(8'($urandom), 8'($urandom), 9'($urandom_range(1, PAYLOAD_MAX)));
    test_random_traffic(10);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/cfr_pkg.sv
src/cfr_if.sv
src/cfr_store.sv
src/cfr_parser.sv
src/crc_checked_frame_receiver_core.sv
dv/crc_checked_frame_receiver_core_tb.sv
